FILE: hw/rtl/tme_pkg.sv
// Shared constants, codes and control structs for the tape machine executor.
// No dependencies; every RTL file of the block imports this package.
package tme_pkg;

	// Sizing
	localparam int TAPE_DEPTH = 32768;
	localparam int LOOP_DEPTH = 64;
	localparam int ADDR_BITS  = 16;

	localparam int BYTE_W = 8;
	localparam int WORD_W = 16;
	localparam int PTR_W  = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
	localparam int FILL_W = PTR_W + 1;
	localparam int STK_W  = $clog2(LOOP_DEPTH + 1);
	localparam int SIDX_W = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;

	// Pushed return addresses wrap to ADDR_BITS
	localparam logic [WORD_W-1:0] ADDR_MASK = WORD_W'((64'd1 << ADDR_BITS) - 64'd1);

	// Item kinds
	localparam logic [1:0] KIND_INSTR   = 2'd0;
	localparam logic [1:0] KIND_CONSOLE = 2'd1;
	localparam logic [1:0] KIND_EOF     = 2'd2;

	// Command bytes
	localparam logic [BYTE_W-1:0] CMD_OPEN  = 8'h5B;
	localparam logic [BYTE_W-1:0] CMD_CLOSE = 8'h5D;
	localparam logic [BYTE_W-1:0] CMD_INC   = 8'h2B;
	localparam logic [BYTE_W-1:0] CMD_DEC   = 8'h2D;
	localparam logic [BYTE_W-1:0] CMD_RIGHT = 8'h3E;
	localparam logic [BYTE_W-1:0] CMD_LEFT  = 8'h3C;
	localparam logic [BYTE_W-1:0] CMD_OUT   = 8'h2E;
	localparam logic [BYTE_W-1:0] CMD_IN    = 8'h2C;

	typedef enum logic [2:0] {
		ACT_CONTINUE = 3'd0,
		ACT_OUTPUT   = 3'd1,
		ACT_JUMP     = 3'd2,
		ACT_REQUEST  = 3'd3,
		ACT_HALT     = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		ERR_NONE  = 3'd0,
		ERR_BELOW = 3'd1,
		ERR_PAST  = 3'd2,
		ERR_UNBAL = 3'd3,
		ERR_DEEP  = 3'd4
	} err_t;

	// Tape operation for one executed beat
	typedef struct packed {
		logic              mv_right;
		logic              mv_left;
		logic              wr;
		logic [BYTE_W-1:0] wr_data;
	} tape_cmd_t;

	// Loop stack operation for one executed beat
	typedef struct packed {
		logic              push;
		logic              pop;
		logic [WORD_W-1:0] push_data;
	} stack_cmd_t;

endpackage

FILE: hw/rtl/tme_tape.sv
// Tape store: one synchronous byte memory plus a three-cell window around the pointer.
// Cells at or past the fill count read as zero. Depends on tme_pkg.
module tme_tape (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tme_pkg::tape_cmd_t         cmd,
	output logic [tme_pkg::PTR_W-1:0]  ptr,
	output logic [tme_pkg::BYTE_W-1:0] cur_byte
);
	import tme_pkg::*;

	logic [BYTE_W-1:0] mem [TAPE_DEPTH];

	logic [PTR_W-1:0]  ptr_q;
	logic [PTR_W-1:0]  rd_addr;
	logic [FILL_W-1:0] fill_q;
	logic [BYTE_W-1:0] l_q, c_q, r_q;
	logic [BYTE_W-1:0] rdata_s1;
	logic              zero_s1;
	logic              lmem_q, rmem_q;
	logic [BYTE_W-1:0] fetched, l_eff, r_eff;
	logic              fresh, wr_en;
	logic [BYTE_W-1:0] wr_data;

	// Current cell is the first one not yet initialized in memory
	assign fresh   = ({1'b0, ptr_q} == fill_q);
	assign wr_en   = cmd.wr || (cmd.mv_right && fresh);
	assign wr_data = cmd.wr ? cmd.wr_data : '0;

	// Prefetch the cell two away in the direction of travel
	assign rd_addr = cmd.mv_right ? ptr_q + PTR_W'(2) : ptr_q - PTR_W'(2);

	assign fetched = zero_s1 ? '0 : rdata_s1;
	assign l_eff   = lmem_q ? fetched : l_q;
	assign r_eff   = rmem_q ? fetched : r_q;

	// Memory port: write the current cell, read the prefetch cell
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[ptr_q] <= wr_data;
		end
		rdata_s1 <= mem[rd_addr];
		zero_s1  <= ({1'b0, rd_addr} >= fill_q);
	end

	// Advance the window and pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			fill_q <= '0;
			l_q    <= '0;
			c_q    <= '0;
			r_q    <= '0;
			lmem_q <= 1'b0;
			rmem_q <= 1'b0;
		end else begin
			if (wr_en && fresh) begin
				fill_q <= fill_q + FILL_W'(1);
			end
			if (cmd.mv_right) begin
				ptr_q  <= ptr_q + PTR_W'(1);
				l_q    <= c_q;
				c_q    <= r_eff;
				lmem_q <= 1'b0;
				rmem_q <= 1'b1;
			end else if (cmd.mv_left) begin
				ptr_q  <= ptr_q - PTR_W'(1);
				r_q    <= c_q;
				c_q    <= l_eff;
				lmem_q <= 1'b1;
				rmem_q <= 1'b0;
			end else begin
				l_q    <= l_eff;
				r_q    <= r_eff;
				lmem_q <= 1'b0;
				rmem_q <= 1'b0;
				if (cmd.wr) begin
					c_q <= cmd.wr_data;
				end
			end
		end
	end

	assign ptr      = ptr_q;
	assign cur_byte = c_q;

endmodule

FILE: hw/rtl/tme_lstack.sv
// Loop-return stack: synchronous memory with the top two entries held in registers.
// Entries are undefined until pushed. Depends on tme_pkg.
module tme_lstack (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tme_pkg::stack_cmd_t        cmd,
	output logic [tme_pkg::WORD_W-1:0] tos,
	output logic [tme_pkg::STK_W-1:0]  count
);
	import tme_pkg::*;

	logic [WORD_W-1:0] mem [LOOP_DEPTH];

	logic [STK_W-1:0]  cnt_q;
	logic [WORD_W-1:0] tos_q, sec_q, rdata_s1, sec_eff;
	logic              secmem_q;
	logic [SIDX_W-1:0] wr_idx, rd_idx;

	assign wr_idx  = cnt_q[SIDX_W-1:0];
	assign rd_idx  = cnt_q[SIDX_W-1:0] - SIDX_W'(3);
	assign sec_eff = secmem_q ? rdata_s1 : sec_q;

	// Memory port: push writes the new top, a pop prefetches the new second entry
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wr_idx] <= cmd.push_data;
		end
		rdata_s1 <= mem[rd_idx];
	end

	// Shift the top two registers
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			tos_q <= cmd.push_data;
			sec_q <= tos_q;
		end else if (cmd.pop) begin
			tos_q <= sec_eff;
		end else begin
			sec_q <= sec_eff;
		end
	end

	// Track depth and where the second entry lives
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			secmem_q <= 1'b0;
		end else begin
			secmem_q <= cmd.pop;
			if (cmd.push) begin
				cnt_q <= cnt_q + STK_W'(1);
			end else if (cmd.pop) begin
				cnt_q <= cnt_q - STK_W'(1);
			end
		end
	end

	assign tos   = tos_q;
	assign count = cnt_q;

endmodule

FILE: hw/rtl/tape_machine_executor.sv
// Tape machine executor: runs one command byte per beat against a byte tape and loop stack.
// The result register loads at the edge that accepts the item.
// Throughput: one item per cycle while not stalled; the tape and stack windows prefetch ahead.
// Reset (asynchronous, active low) clears pointer, stack depth, skip depth, request and fault;
// the tape reads as zero beyond a fill count, so no clearing pass is needed after reset.
module tape_machine_executor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  code,
	input  logic [15:0] address,
	input  logic [7:0]  console_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  action,
	output logic [7:0]  byte_out,
	output logic [15:0] jump_address,
	output logic [2:0]  error_code
);
	import tme_pkg::*;

	logic              acc;
	logic [PTR_W-1:0]  ptr;
	logic [BYTE_W-1:0] cur_byte;
	logic [WORD_W-1:0] tos;
	logic [STK_W-1:0]  count;

	tape_cmd_t  tcmd, tcmd_x;
	stack_cmd_t scmd, scmd_x;

	logic [WORD_W-1:0] skip_q, skip_n;
	logic              await_q, await_n;
	err_t              fault_q, fault_n;

	action_t           act_n, action_q;
	err_t              err_n, err_q;
	logic [BYTE_W-1:0] bout_n, byte_out_q;
	logic [WORD_W-1:0] jump_n, jump_q;
	logic              out_valid_q;

	// Accept whenever the result register is free or draining this cycle
	assign in_stall = out_valid_q && out_stall;
	assign acc      = in_valid && !in_stall;

	tme_tape u_tape (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (tcmd),
		.ptr      (ptr),
		.cur_byte (cur_byte)
	);

	tme_lstack u_lstack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (scmd),
		.tos    (tos),
		.count  (count)
	);

	// Decode and execute one beat
	always_comb begin
		tcmd_x  = '0;
		scmd_x  = '0;
		skip_n  = skip_q;
		await_n = await_q;
		fault_n = fault_q;
		act_n   = ACT_CONTINUE;
		err_n   = ERR_NONE;
		bout_n  = '0;
		jump_n  = '0;
		if (fault_q != ERR_NONE) begin
			act_n = ACT_HALT;
			err_n = fault_q;
		end else if (kind inside {KIND_CONSOLE, KIND_EOF}) begin
			if (await_q) begin
				await_n = 1'b0;
				if (kind == KIND_CONSOLE) begin
					tcmd_x.wr      = 1'b1;
					tcmd_x.wr_data = console_byte;
				end
			end
		end else if (kind != KIND_INSTR) begin
			act_n = ACT_CONTINUE;
		end else if (await_q) begin
			act_n = ACT_REQUEST;
		end else if (skip_q != '0) begin
			if (code == CMD_OPEN) begin
				if (skip_q == '1) begin
					err_n = ERR_DEEP;
				end else begin
					skip_n = skip_q + WORD_W'(1);
				end
			end else if (code == CMD_CLOSE) begin
				skip_n = skip_q - WORD_W'(1);
			end
		end else begin
			case (code)
				CMD_OPEN: begin
					if (cur_byte == '0) begin
						skip_n = WORD_W'(1);
					end else if (count >= STK_W'(LOOP_DEPTH)) begin
						err_n = ERR_DEEP;
					end else begin
						scmd_x.push      = 1'b1;
						scmd_x.push_data = (address + WORD_W'(1)) & ADDR_MASK;
					end
				end
				CMD_CLOSE: begin
					if (count == '0) begin
						err_n = ERR_UNBAL;
					end else if (cur_byte != '0) begin
						act_n  = ACT_JUMP;
						jump_n = tos;
					end else begin
						scmd_x.pop = 1'b1;
					end
				end
				CMD_INC: begin
					tcmd_x.wr      = 1'b1;
					tcmd_x.wr_data = cur_byte + BYTE_W'(1);
				end
				CMD_DEC: begin
					tcmd_x.wr      = 1'b1;
					tcmd_x.wr_data = cur_byte - BYTE_W'(1);
				end
				CMD_RIGHT: begin
					if (ptr >= PTR_W'(TAPE_DEPTH - 1)) begin
						err_n = ERR_PAST;
					end else begin
						tcmd_x.mv_right = 1'b1;
					end
				end
				CMD_LEFT: begin
					if (ptr == '0) begin
						err_n = ERR_BELOW;
					end else begin
						tcmd_x.mv_left = 1'b1;
					end
				end
				CMD_OUT: begin
					act_n  = ACT_OUTPUT;
					bout_n = cur_byte;
				end
				CMD_IN: begin
					await_n = 1'b1;
					act_n   = ACT_REQUEST;
				end
				default: begin
					act_n = ACT_CONTINUE;
				end
			endcase
		end
		// A fresh error halts the block and drops the beat's other effects
		if (fault_q == ERR_NONE && err_n != ERR_NONE) begin
			act_n   = ACT_HALT;
			fault_n = err_n;
		end
	end

	// Commit storage operations only on an accepted beat
	assign tcmd = acc ? tcmd_x : '0;
	assign scmd = acc ? scmd_x : '0;

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q  <= '0;
			await_q <= 1'b0;
			fault_q <= ERR_NONE;
		end else if (acc) begin
			skip_q  <= skip_n;
			await_q <= await_n;
			fault_q <= fault_n;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (acc) begin
			action_q   <= act_n;
			err_q      <= err_n;
			byte_out_q <= bout_n;
			jump_q     <= jump_n;
		end
	end

	assign out_valid    = out_valid_q;
	assign action       = action_q;
	assign byte_out     = byte_out_q;
	assign jump_address = jump_q;
	assign error_code   = err_q;

	// A new result appears only after an accepted beat
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(acc))
		else $error("result appeared without an accepted beat");

	// A stored fault never changes until reset
	assert property (@(posedge clk) disable iff (!arst_n)
		fault_q != ERR_NONE |=> fault_q == $past(fault_q))
		else $error("fault changed while halted");

	// Error code is set exactly on halted results
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((action_q == ACT_HALT) == (err_q != ERR_NONE)))
		else $error("error code and halt action disagree");

	// A pending request and bracket skipping never coexist
	assert property (@(posedge clk) disable iff (!arst_n)
		!(await_q && skip_q != '0))
		else $error("request pending while skipping");

	// Never push onto a full stack, never pop an empty one
	assert property (@(posedge clk) disable iff (!arst_n)
		!(scmd.push && count >= STK_W'(LOOP_DEPTH)) && !(scmd.pop && count == '0))
		else $error("loop stack overrun");

endmodule

FILE: bench/tape_machine_executor_tb.sv
// Self-checking bench for tape_machine_executor: directed beats, back-pressure,
// random bracket programs driven by a fetcher, and a final error halt.
// Depends on tme_pkg and the tape_machine_executor RTL.
`timescale 1ns / 1ps

module tape_machine_executor_tb;
	import tme_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int SKIP_LIMIT   = 65535;
	localparam int RANDOM_ITEMS = 420;
	localparam int REPORT_LIMIT = 10;
	localparam int DRAIN_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int PROG_MAX     = 64;
	localparam int PIDX_W       = $clog2(PROG_MAX);
	localparam int STEP_BUDGET  = 150;

	typedef struct packed {
		action_t     act;
		logic [7:0]  byte_val;
		logic [15:0] jump;
		err_t        err;
	} step_result_t;

	typedef enum int {
		ROUTE_BELOW,
		ROUTE_UNBAL,
		ROUTE_STACK
	} halt_route_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  kind = 2'd0;
	logic [7:0]  code = 8'h00;
	logic [15:0] address = 16'h0000;
	logic [7:0]  console_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  action;
	logic [7:0]  byte_out;
	logic [15:0] jump_address;
	logic [2:0]  error_code;

	// Machine state as the bench expects it
	logic [7:0]  tape_mem [TAPE_DEPTH];
	logic [15:0] return_stack [LOOP_DEPTH];
	int          cell_ptr = 0;
	int          open_loops = 0;
	int          skip_level = 0;
	bit          console_wait = 1'b0;
	err_t        halt_code = ERR_NONE;

	step_result_t expected_results [$];
	int mismatches = 0;
	int beats_sent = 0;
	int results_seen = 0;
	int work_items = 0;
	int result_gap = 0;
	bit hold_results = 1'b0;
	bit no_idle = 1'b0;

	tape_machine_executor u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.code         (code),
		.address      (address),
		.console_byte (console_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.action       (action),
		.byte_out     (byte_out),
		.jump_address (jump_address),
		.error_code   (error_code)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic bit is_command(logic [7:0] c);
		case (c)
			CMD_OPEN, CMD_CLOSE, CMD_INC, CMD_DEC,
			CMD_RIGHT, CMD_LEFT, CMD_OUT, CMD_IN: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// Random byte that the machine ignores
	function automatic logic [7:0] filler_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (is_command(b));
		return b;
	endfunction

	function automatic step_result_t raise_fault(err_t e);
		step_result_t r;
		halt_code = e;
		r = '{ACT_HALT, 8'h00, 16'h0000, e};
		return r;
	endfunction

	// Advance the expected machine by one beat and return its answer
	function automatic step_result_t execute_beat(logic [1:0] k, logic [7:0] c,
			logic [15:0] a, logic [7:0] cb);
		step_result_t r;
		logic [7:0] cur;
		r = '{ACT_CONTINUE, 8'h00, 16'h0000, ERR_NONE};
		if (halt_code != ERR_NONE) begin
			r.act = ACT_HALT;
			r.err = halt_code;
			return r;
		end
		// console beats only matter while a request is open
		if (k == KIND_CONSOLE || k == KIND_EOF) begin
			if (console_wait) begin
				if (k == KIND_CONSOLE)
					tape_mem[PTR_W'(cell_ptr)] = cb;
				console_wait = 1'b0;
			end
			return r;
		end
		if (k != KIND_INSTR)
			return r;
		if (console_wait) begin
			r.act = ACT_REQUEST;
			return r;
		end
		// while skipping, only track bracket nesting
		if (skip_level != 0) begin
			if (c == CMD_OPEN) begin
				if (skip_level >= SKIP_LIMIT)
					return raise_fault(ERR_DEEP);
				skip_level++;
			end else if (c == CMD_CLOSE) begin
				skip_level--;
			end
			return r;
		end
		cur = tape_mem[PTR_W'(cell_ptr)];
		case (c)
			CMD_OPEN: begin
				if (cur == 8'h00) begin
					skip_level = 1;
				end else if (open_loops >= LOOP_DEPTH) begin
					return raise_fault(ERR_DEEP);
				end else begin
					return_stack[SIDX_W'(open_loops)] = (a + 16'd1) & ADDR_MASK;
					open_loops++;
				end
			end
			CMD_CLOSE: begin
				if (open_loops == 0)
					return raise_fault(ERR_UNBAL);
				if (cur != 8'h00) begin
					r.act = ACT_JUMP;
					r.jump = return_stack[SIDX_W'(open_loops - 1)];
				end else begin
					open_loops--;
				end
			end
			CMD_INC: tape_mem[PTR_W'(cell_ptr)] = cur + 8'd1;
			CMD_DEC: tape_mem[PTR_W'(cell_ptr)] = cur - 8'd1;
			CMD_RIGHT: begin
				if (cell_ptr >= TAPE_DEPTH - 1)
					return raise_fault(ERR_PAST);
				cell_ptr++;
			end
			CMD_LEFT: begin
				if (cell_ptr == 0)
					return raise_fault(ERR_BELOW);
				cell_ptr--;
			end
			CMD_OUT: begin
				r.act = ACT_OUTPUT;
				r.byte_val = cur;
			end
			CMD_IN: begin
				console_wait = 1'b1;
				r.act = ACT_REQUEST;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic log_failure(input string msg);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0t: %s", $time, msg);
	endtask

	// Offer one beat, hold it until accepted, then queue its expected answer.
	// Called and left at a falling edge.
	task automatic send_beat(input logic [1:0] k, input logic [7:0] c,
			input logic [15:0] a, input logic [7:0] cb, output step_result_t res);
		int gap;
		bit live;
		gap = (no_idle || (beats_sent / 40) % 4 == 1) ? 0 : int'($urandom_range(0, 14));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		code <= c;
		address <= a;
		console_byte <= cb;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		live = (k == KIND_INSTR) ? is_command(c) : (k != KIND_UNUSED && console_wait);
		res = execute_beat(k, c, a, cb);
		expected_results = {expected_results, res};
		beats_sent++;
		if (live)
			work_items++;
		@(negedge clk);
	endtask

	task automatic send_instr(input logic [7:0] c, input logic [15:0] a,
			output step_result_t res);
		send_beat(KIND_INSTR, c, a, 8'($urandom_range(0, 255)), res);
	endtask

	// Drop valid and wait for every expected result
	task automatic pause_until_drained();
		int waited;
		in_valid <= 1'b0;
		waited = 0;
		@(posedge clk);
		while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		@(negedge clk);
	endtask

	// Close any open request, skip or loop so the machine is back at top level
	task automatic unwind_loops();
		step_result_t res;
		while (console_wait || skip_level != 0 || open_loops != 0) begin
			if (console_wait)
				send_beat(KIND_CONSOLE, 8'h00, 16'h0000, 8'h00, res);
			else if (skip_level != 0 || tape_mem[PTR_W'(cell_ptr)] == 8'h00)
				send_instr(CMD_CLOSE, 16'($urandom_range(0, 65534)), res);
			else
				send_instr(CMD_IN, 16'($urandom_range(0, 65534)), res);
		end
	endtask

	// Build a balanced program and fetch it, following jumps and answering requests
	task automatic run_program();
		logic [7:0] prog [PROG_MAX];
		step_result_t res;
		logic [15:0] base;
		logic [7:0] op;
		int plen, depth, pc, steps, pick;
		plen = 0;
		depth = 0;
		repeat ($urandom_range(4, 40)) begin
			pick = int'($urandom_range(0, 19));
			case (pick)
				0, 1: op = (depth < 3) ? CMD_OPEN : CMD_INC;
				2, 3: op = (depth > 0) ? CMD_CLOSE : CMD_DEC;
				4, 5, 6: op = CMD_INC;
				7, 8, 9, 18: op = CMD_DEC;
				10, 11, 19: op = CMD_RIGHT;
				12, 13: op = CMD_LEFT;
				14, 15: op = CMD_OUT;
				16: op = CMD_IN;
				default: op = filler_byte();
			endcase
			if (op == CMD_OPEN)
				depth++;
			if (op == CMD_CLOSE)
				depth--;
			prog[PIDX_W'(plen)] = op;
			plen++;
		end
		while (depth > 0) begin
			prog[PIDX_W'(plen)] = CMD_CLOSE;
			plen++;
			depth--;
		end
		// now and then place the program so it ends just below the top address
		base = ($urandom_range(0, 7) == 0) ? 16'(65535 - plen)
			: 16'($urandom_range(0, 65535 - plen));
		pc = 0;
		steps = 0;
		while (pc < plen && steps < STEP_BUDGET) begin
			if ($urandom_range(0, 11) == 0) begin
				// ignored beats: unused kind, console or end-of-file beat with nothing requested
				pick = int'($urandom_range(0, 2));
				send_beat((pick == 0) ? KIND_UNUSED : (pick == 1) ? KIND_CONSOLE : KIND_EOF,
					8'($urandom_range(0, 255)), 16'($urandom_range(0, 65534)),
					8'($urandom_range(0, 255)), res);
			end
			op = prog[PIDX_W'(pc)];
			// keep the pointer on the tape
			if (op == CMD_LEFT && cell_ptr == 0 && skip_level == 0)
				op = filler_byte();
			send_instr(op, base + 16'(pc), res);
			steps++;
			if (res.act == ACT_JUMP) begin
				pc = int'(res.jump) - int'(base);
			end else begin
				if (res.act == ACT_REQUEST) begin
					// instruction fetched while the request is still open
					if ($urandom_range(0, 3) == 0)
						send_instr(8'($urandom_range(0, 255)),
							16'($urandom_range(0, 65534)), res);
					if ($urandom_range(0, 5) == 0)
						send_beat(KIND_EOF, 8'($urandom_range(0, 255)),
							16'($urandom_range(0, 65534)), 8'($urandom_range(0, 255)), res);
					else
						send_beat(KIND_CONSOLE, 8'($urandom_range(0, 255)),
							16'($urandom_range(0, 65534)), 8'($urandom_range(0, 255)), res);
				end
				pc++;
			end
		end
		unwind_loops();
	endtask

	task automatic test_directed();
		step_result_t res;
		send_instr(CMD_OUT, 16'h0000, res);
		send_instr(CMD_DEC, 16'hFFFE, res);
		send_instr(CMD_OUT, 16'h8000, res);
		send_instr(CMD_INC, 16'h0001, res);
		send_instr(CMD_INC, 16'h0002, res);
		// loop opened just below the top address returns to the top address
		send_instr(CMD_OPEN, 16'hFFFE, res);
		send_instr(CMD_CLOSE, 16'h0003, res);
		send_instr(CMD_DEC, 16'h0004, res);
		send_instr(CMD_CLOSE, 16'h0005, res);
		// zero cell: skip over a nested pair
		send_instr(CMD_OPEN, 16'h0010, res);
		send_instr(CMD_OPEN, 16'h0011, res);
		send_instr(CMD_OUT, 16'h0012, res);
		send_instr(CMD_CLOSE, 16'h0013, res);
		send_instr(CMD_CLOSE, 16'h0014, res);
		// request, instruction while pending, answer, stray console byte
		send_instr(CMD_IN, 16'h0020, res);
		send_instr(CMD_INC, 16'h0021, res);
		send_beat(KIND_CONSOLE, 8'h00, 16'h0000, 8'hA5, res);
		send_beat(KIND_CONSOLE, 8'hFF, 16'hFFFE, 8'h5A, res);
		send_instr(CMD_OUT, 16'h0022, res);
		// console exhausted keeps the cell
		send_instr(CMD_IN, 16'h0023, res);
		send_beat(KIND_EOF, 8'h00, 16'h0000, 8'hFF, res);
		send_beat(KIND_UNUSED, 8'hFF, 16'hFFFE, 8'hFF, res);
		send_instr(CMD_RIGHT, 16'h0024, res);
		send_instr(CMD_LEFT, 16'h0025, res);
		send_instr(8'hFF, 16'h7FFF, res);
		pause_until_drained();
	endtask

	// Hold off results for a long stretch while beats keep coming
	task automatic test_backpressure();
		step_result_t res;
		logic [15:0] pos;
		pos = 16'($urandom_range(0, 60000));
		no_idle = 1'b1;
		fork
			begin
				@(posedge clk);
				hold_results = 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_results = 1'b0;
			end
		join_none
		repeat (60) begin
			case ($urandom_range(0, 3))
				0: send_instr(CMD_INC, pos, res);
				1: send_instr(CMD_DEC, pos, res);
				2: send_instr(CMD_OUT, pos, res);
				default: send_instr(CMD_RIGHT, pos, res);
			endcase
			pos++;
		end
		no_idle = 1'b0;
		pause_until_drained();
	endtask

	task automatic test_random_programs();
		int target;
		target = work_items + RANDOM_ITEMS;
		while (work_items < target)
			run_program();
		pause_until_drained();
	endtask

	// Drive one randomly chosen error, then check the halted answers
	task automatic test_halt();
		step_result_t res;
		halt_route_t route;
		logic [7:0] op;
		route = halt_route_t'($urandom_range(0, 2));
		unwind_loops();
		no_idle = 1'b1;
		case (route)
			ROUTE_BELOW: op = CMD_LEFT;
			ROUTE_UNBAL: op = CMD_CLOSE;
			default: begin
				op = CMD_OPEN;
				if (tape_mem[PTR_W'(cell_ptr)] == 8'h00)
					send_instr(CMD_INC, 16'($urandom_range(0, 65534)), res);
			end
		endcase
		while (halt_code == ERR_NONE)
			send_instr(op, 16'($urandom_range(0, 65534)), res);
		no_idle = 1'b0;
		repeat (8)
			send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
				16'($urandom_range(0, 65534)), 8'($urandom_range(0, 255)), res);
		pause_until_drained();
	endtask

	// Check each result beat against the oldest expectation
	always @(posedge clk) begin : take_results
		step_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				log_failure($sformatf("unexpected result: action %0d byte %02h jump %04h error %0d",
					action, byte_out, jump_address, error_code));
			end else begin
				want = expected_results.pop_front();
				if (action !== want.act || byte_out !== want.byte_val
						|| jump_address !== want.jump || error_code !== want.err)
					log_failure($sformatf({"result %0d: expected action %0d byte %02h jump %04h",
						" error %0d, got action %0d byte %02h jump %04h error %0d"},
						results_seen, want.act, want.byte_val, want.jump, want.err,
						action, byte_out, jump_address, error_code));
			end
			result_gap = (no_idle || (results_seen / 40) % 4 == 3) ? 0
				: int'($urandom_range(0, 14));
		end else if (result_gap > 0) begin
			result_gap--;
		end
	end

	always @(negedge clk) begin
		out_stall <= hold_results || result_gap > 0;
	end

	initial begin
		for (int i = 0; i < TAPE_DEPTH; i++)
			tape_mem[PTR_W'(i)] = 8'h00;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_backpressure();
		test_random_programs();
		test_halt();
		repeat (10) @(posedge clk);
		if (expected_results.size() != 0)
			$display("%0d expected results never arrived", expected_results.size());
		if (mismatches == 0 && expected_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("timeout");
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
